FILE: design/cau_pkg.sv
// Package for the complex arithmetic unit.
// Holds widths, operation codes, item and pipeline types, and saturation helpers.
// Depends on nothing.
package cau_pkg;

  localparam int DW  = 16;        // data word width
  localparam int FB  = 8;         // fractional bits
  localparam int PW  = 2 * DW;    // product width
  localparam int SW  = PW + 2;    // width of sums of products
  localparam int QB  = DW + 1;    // quotient and root bits
  localparam int NSTEP = QB;      // iteration stages
  localparam int RW  = PW;        // divider remainder width
  localparam int VW  = PW + 2;    // root radicand width
  localparam int SRW = QB + 4;    // root remainder width

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_NEG  = 3'd4,
    ACT_CONJ = 3'd5,
    ACT_MAG  = 3'd6
  } cau_act_e;

  typedef struct packed {
    logic [2:0]           action;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 overflow;
    logic                 div_zero;
  } cau_out_t;

  typedef struct packed {
    logic [DW-1:0] v;
    logic          ov;
  } sat_t;

  typedef struct packed {
    logic          valid;
    logic [2:0]    act;
    logic          dz;
    sat_t          sre;
    sat_t          sim;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic [RW-1:0] den;
    logic [RW-1:0] rre;
    logic [RW-1:0] rim;
    logic [QB-1:0] qre;
    logic [QB-1:0] qim;
    logic [QB-1:0] dre;
    logic [QB-1:0] dim;
    logic [VW-1:0] v;
    logic [SRW-1:0] sr;
    logic [QB-1:0] sq;
  } cau_iter_t;

  // clip a signed value to the word range
  function automatic sat_t sat_s(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    sat_t r;
    hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (x > hi) begin
      r.v = hi[DW-1:0];
      r.ov = 1'b1;
    end else if (x < lo) begin
      r.v = lo[DW-1:0];
      r.ov = 1'b1;
    end else begin
      r.v = x[DW-1:0];
      r.ov = 1'b0;
    end
    return r;
  endfunction

  // clip a sign and magnitude value; big marks a magnitude past the quotient range
  function automatic sat_t sat_m(input logic neg, input logic [QB-1:0] mag,
                                 input logic big);
    logic [QB-1:0] lim;
    sat_t r;
    lim = QB'(1) << (DW - 1);
    if (!neg) begin
      if (big || mag > lim - QB'(1)) begin
        r.v = {1'b0, {(DW-1){1'b1}}};
        r.ov = 1'b1;
      end else begin
        r.v = mag[DW-1:0];
        r.ov = 1'b0;
      end
    end else begin
      if (big || mag > lim) begin
        r.v = {1'b1, {(DW-1){1'b0}}};
        r.ov = 1'b1;
      end else begin
        r.v = DW'(0) - mag[DW-1:0];
        r.ov = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

FILE: design/cau_front.sv
// Front end of the complex arithmetic unit: products, sums and divider setup.
// Three register stages. Depends on cau_pkg.
module cau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cau_pkg::cau_in_t  in_i,
  output cau_pkg::cau_iter_t s_o
);
  import cau_pkg::*;

  // stage 1: products and the cheap operations
  logic                 v1_q;
  logic [2:0]           act1_q;
  sat_t                 sre1_q, sim1_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q, pir_q, ps0_q, ps1_q;
  sat_t                 sre1_d, sim1_d;
  logic signed [DW-1:0] m0, m1;
  logic signed [SW-1:0] ar, ai, br, bi;

  always_comb begin
    ar = SW'(in_i.a_re);
    ai = SW'(in_i.a_im);
    br = SW'(in_i.b_re);
    bi = SW'(in_i.b_im);
    m0 = (cau_act_e'(in_i.action) == ACT_MAG) ? in_i.a_re : in_i.b_re;
    m1 = (cau_act_e'(in_i.action) == ACT_MAG) ? in_i.a_im : in_i.b_im;
    sre1_d = '0;
    sim1_d = '0;
    case (cau_act_e'(in_i.action))
      ACT_ADD: begin
        sre1_d = sat_s(ar + br);
        sim1_d = sat_s(ai + bi);
      end
      ACT_SUB: begin
        sre1_d = sat_s(ar - br);
        sim1_d = sat_s(ai - bi);
      end
      ACT_NEG: begin
        sre1_d = sat_s(-ar);
        sim1_d = sat_s(-ai);
      end
      ACT_CONJ: begin
        sre1_d = sat_s(ar);
        sim1_d = sat_s(-ai);
      end
      default: begin
        sre1_d = '0;
        sim1_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    act1_q <= in_i.action;
    sre1_q <= sre1_d;
    sim1_q <= sim1_d;
    prr_q  <= in_i.a_re * in_i.b_re;
    pii_q  <= in_i.a_im * in_i.b_im;
    pri_q  <= in_i.a_re * in_i.b_im;
    pir_q  <= in_i.a_im * in_i.b_re;
    ps0_q  <= m0 * m0;
    ps1_q  <= m1 * m1;
  end

  // stage 2: sums of products, multiply result
  logic                 v2_q;
  logic [2:0]           act2_q;
  sat_t                 sre2_q, sim2_q, sre2_d, sim2_d;
  logic signed [SW-1:0] nre_q, nim_q;
  logic [RW-1:0]        den_q;
  logic signed [SW-1:0] mre, mim;

  always_comb begin
    mre = (SW'(prr_q) - SW'(pii_q)) >>> FB;
    mim = (SW'(pri_q) + SW'(pir_q)) >>> FB;
    sre2_d = sre1_q;
    sim2_d = sim1_q;
    if (cau_act_e'(act1_q) == ACT_MUL) begin
      sre2_d = sat_s(mre);
      sim2_d = sat_s(mim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act2_q <= act1_q;
    sre2_q <= sre2_d;
    sim2_q <= sim2_d;
    nre_q  <= SW'(prr_q) + SW'(pii_q);
    nim_q  <= SW'(pir_q) - SW'(pri_q);
    den_q  <= RW'(ps0_q) + RW'(ps1_q);
  end

  // stage 3: sign and magnitude, range check, first remainder
  cau_iter_t s_d, s_q;
  logic [SW-1:0] mag_re, mag_im;

  always_comb begin
    mag_re = nre_q[SW-1] ? SW'(-nre_q) : SW'(nre_q);
    mag_im = nim_q[SW-1] ? SW'(-nim_q) : SW'(nim_q);
    s_d        = '0;
    s_d.valid  = v2_q;
    s_d.act    = act2_q;
    s_d.dz     = (cau_act_e'(act2_q) == ACT_DIV) && (den_q == '0);
    s_d.sre    = sre2_q;
    s_d.sim    = sim2_q;
    s_d.neg_re = nre_q[SW-1];
    s_d.neg_im = nim_q[SW-1];
    s_d.big_re = (mag_re >> (QB - FB)) >= SW'(den_q);
    s_d.big_im = (mag_im >> (QB - FB)) >= SW'(den_q);
    s_d.den    = den_q;
    s_d.rre    = RW'(mag_re >> (QB - FB));
    s_d.rim    = RW'(mag_im >> (QB - FB));
    s_d.dre    = {mag_re[QB-FB-1:0], {FB{1'b0}}};
    s_d.dim    = {mag_im[QB-FB-1:0], {FB{1'b0}}};
    s_d.v      = VW'(den_q);
  end

  // only the valid bit is cleared; the data fields follow it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q.valid <= 1'b0;
    end else begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

FILE: design/cau_iter.sv
// One stage of the shared quotient and root pipeline.
// Takes one quotient bit for both parts and one root bit. Depends on cau_pkg.
module cau_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cau_pkg::cau_iter_t s_i,
  output cau_pkg::cau_iter_t s_o
);
  import cau_pkg::*;

  cau_iter_t     s_d, s_q;
  logic [RW:0]   xre, xim;
  logic [SRW-1:0] xr, tr;

  always_comb begin
    s_d = s_i;
    // restoring divide step, real part
    xre = {s_i.rre, s_i.dre[QB-1]};
    if (xre >= {1'b0, s_i.den}) begin
      s_d.rre = RW'(xre - {1'b0, s_i.den});
      s_d.qre = {s_i.qre[QB-2:0], 1'b1};
    end else begin
      s_d.rre = xre[RW-1:0];
      s_d.qre = {s_i.qre[QB-2:0], 1'b0};
    end
    // imaginary part
    xim = {s_i.rim, s_i.dim[QB-1]};
    if (xim >= {1'b0, s_i.den}) begin
      s_d.rim = RW'(xim - {1'b0, s_i.den});
      s_d.qim = {s_i.qim[QB-2:0], 1'b1};
    end else begin
      s_d.rim = xim[RW-1:0];
      s_d.qim = {s_i.qim[QB-2:0], 1'b0};
    end
    s_d.dre = {s_i.dre[QB-2:0], 1'b0};
    s_d.dim = {s_i.dim[QB-2:0], 1'b0};
    // square root step: bring down two radicand bits
    xr = {s_i.sr[SRW-3:0], s_i.v[VW-1:VW-2]};
    tr = SRW'({s_i.sq, 2'b01});
    if (xr >= tr) begin
      s_d.sr = xr - tr;
      s_d.sq = {s_i.sq[QB-2:0], 1'b1};
    end else begin
      s_d.sr = xr;
      s_d.sq = {s_i.sq[QB-2:0], 1'b0};
    end
    s_d.v = {s_i.v[VW-3:0], 2'b00};
  end

  // only the valid bit is cleared; the data fields follow it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q.valid <= 1'b0;
    end else begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

FILE: design/cau_back.sv
// Output stage of the complex arithmetic unit: result selection and clipping.
// Depends on cau_pkg.
module cau_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cau_pkg::cau_iter_t s_i,
  output logic               valid_o,
  output cau_pkg::cau_out_t  res_o
);
  import cau_pkg::*;

  logic     valid_q;
  cau_out_t res_q, res_d;
  sat_t     dre, dim, mg;

  always_comb begin
    dre = sat_m(s_i.neg_re, s_i.qre, s_i.big_re);
    dim = sat_m(s_i.neg_im, s_i.qim, s_i.big_im);
    mg  = sat_m(1'b0, s_i.sq, 1'b0);
    res_d = '0;
    case (cau_act_e'(s_i.act))
      ACT_DIV: begin
        if (s_i.dz) begin
          res_d.div_zero = 1'b1;
        end else begin
          res_d.res_re   = dre.v;
          res_d.res_im   = dim.v;
          res_d.overflow = dre.ov | dim.ov;
        end
      end
      ACT_MAG: begin
        res_d.res_re   = mg.v;
        res_d.overflow = mg.ov;
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_NEG, ACT_CONJ: begin
        res_d.res_re   = s_i.sre.v;
        res_d.res_im   = s_i.sim.v;
        res_d.overflow = s_i.sre.ov | s_i.sim.ov;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: design/complex_arith_unit.sv
// Complex arithmetic unit on signed Q8.8 operands: add, sub, mul, div, negate,
// conjugate and magnitude. One item is taken in every cycle; busy_o stays low, and each
// result appears on res_o with valid_o high for one cycle, after passing through
// three front stages for products and sums, seventeen stages of the shared
// quotient and square root pipeline (one bit each), and the output register.
// Depends on cau_pkg, cau_front, cau_iter and cau_back.
module complex_arith_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cau_pkg::cau_in_t  in_i,
  output logic              valid_o,
  output cau_pkg::cau_out_t res_o
);
  import cau_pkg::*;

  cau_iter_t stg [NSTEP+1];

  assign busy_o = 1'b0;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .in_i    (in_i),
    .s_o     (stg[0])
  );

  for (genvar k = 0; k < NSTEP; k++) begin : g_iter
    cau_iter u_iter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .s_i    (stg[k]),
      .s_o    (stg[k+1])
    );
  end

  cau_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_i     (stg[NSTEP]),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

FILE: verif/complex_arith_unit_chk.sv
`timescale 1ns / 100ps
// Result checker for the complex arithmetic unit: predicts each accepted item
// and compares the strobed results in order. Depends on cau_pkg.
module complex_arith_unit_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  cau_pkg::cau_in_t  in_i,
  input  logic              valid_i,
  input  cau_pkg::cau_out_t res_i,
  output int                fail_cnt_o,
  output int                pending_o
);
  import cau_pkg::*;

  cau_out_t expected_q[$];

  function automatic logic signed [DW-1:0] clip(input longint v, inout logic ov);
    if (v > 32767) begin
      ov = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ov = 1'b1;
      return 16'sh8000;
    end
    return v[DW-1:0];
  endfunction

  // floor of x / 2^FB
  function automatic longint fl_shift(input longint x);
    return x >>> FB;
  endfunction

  // truncate toward zero of x * 2^FB / d, capped above the output range
  function automatic longint qdiv(input longint x, input longint d);
    longint m, q;
    m = (x < 0) ? -x : x;
    q = (m * (64'sd1 << FB)) / d;
    if (q > (64'sd1 << (DW + 1))) q = 64'sd1 << (DW + 1);
    return (x < 0) ? -q : q;
  endfunction

  function automatic longint root(input longint v);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r = r + (64'sd1 << b);
    end
    return r;
  endfunction

  function automatic cau_out_t predict_result(input cau_in_t it);
    longint ar, ai, br, bi, re, im, den;
    cau_out_t o;
    ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
    re = 0; im = 0;
    o = '0;
    case (it.action)
      ACT_ADD: begin re = ar + br; im = ai + bi; end
      ACT_SUB: begin re = ar - br; im = ai - bi; end
      ACT_MUL: begin
        re = fl_shift(ar * br - ai * bi);
        im = fl_shift(ar * bi + ai * br);
      end
      ACT_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) o.div_zero = 1'b1;
        else begin
          re = qdiv(ar * br + ai * bi, den);
          im = qdiv(ai * br - ar * bi, den);
        end
      end
      ACT_NEG: begin re = -ar; im = -ai; end
      ACT_CONJ: begin re = ar; im = -ai; end
      ACT_MAG: re = root(ar * ar + ai * ai);
      default: ;
    endcase
    o.res_re = clip(re, o.overflow);
    o.res_im = clip(im, o.overflow);
    return o;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cau_out_t e;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
    end else begin
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no item waiting: %h", res_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (res_i !== e) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (res_i.res_re !== e.res_re)
              $error("res_re exp %0d got %0d", e.res_re, res_i.res_re);
            if (res_i.res_im !== e.res_im)
              $error("res_im exp %0d got %0d", e.res_im, res_i.res_im);
            if (res_i.overflow !== e.overflow)
              $error("overflow exp %b got %b", e.overflow, res_i.overflow);
            if (res_i.div_zero !== e.div_zero)
              $error("div_zero exp %b got %b", e.div_zero, res_i.div_zero);
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(predict_result(in_i));
    end
  end
endmodule

FILE: verif/complex_arith_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the complex arithmetic unit: clock, reset, directed and
// random items, verdict. Depends on cau_pkg and complex_arith_unit_chk.
module complex_arith_unit_tb;
  import cau_pkg::*;

  logic     clk_i, rst_ni, start_i, busy_o, valid_o;
  cau_in_t  in_i;
  cau_out_t res_o;
  int       fail_cnt, pending;

  complex_arith_unit dut (.clk_i, .rst_ni, .start_i, .busy_o, .in_i, .valid_o, .res_o);

  complex_arith_unit_chk u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_i, .valid_i(valid_o),
    .res_i(res_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000 + 16'($urandom_range(0, 2));
      1: return 16'h7fff - 16'($urandom_range(0, 2));
      2: return 16'($urandom_range(0, 3) - 1);
      3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // hold the item until accepted; idle before it at random unless quiet
  task automatic send_item(input cau_in_t it, input bit quiet);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 33) begin
        start_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    start_i <= 1'b1;
    in_i    <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    cau_in_t it;
    logic [15:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h0100};
    start_i = 1'b0;
    in_i    = '0;
    rst_ni  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni  = 1'b1;
    @(negedge clk_i);
    // directed: every operation on the extremes, zero divisor, unused code
    for (int op = 0; op < 8; op++) begin
      it = '{action: op[2:0], a_re: 16'h8000, a_im: 16'h8000, b_re: 16'h7fff, b_im: 16'h8000};
      send_item(it, 1'b0);
      it = '{action: op[2:0], a_re: 16'h7fff, a_im: 16'h7fff, b_re: 16'h0000, b_im: 16'h0000};
      send_item(it, 1'b0);
    end
    for (int k = 0; k < 6; k++) begin
      it = '{action: ACT_DIV, a_re: ext[k], a_im: ext[5 - k], b_re: ext[(k + 2) % 6],
             b_im: 16'h0001};
      send_item(it, 1'b0);
    end
    for (int n = 0; n < 1300; n++) begin
      it.action = (n % 10 == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      it.a_re = pick_val();
      it.a_im = pick_val();
      it.b_re = ($urandom_range(0, 19) == 0) ? 16'h0 : pick_val();
      it.b_im = ($urandom_range(0, 19) == 0) ? 16'h0 : pick_val();
      send_item(it, n >= 400 && n < 600);
    end
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: complex_arith_unit.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_iter.sv
design/cau_back.sv
design/complex_arith_unit.sv
verif/complex_arith_unit_chk.sv
verif/complex_arith_unit_tb.sv
